// File: hw/rtl/arc_pkg.sv
// Shared types, codes and defaults for the ARP resolver cache.
`timescale 1ns / 1ps

package arc_pkg;

  // Default table sizes.
  localparam int MAP_ENTRIES_DEF  = 16;
  localparam int PENDING_HOPS_DEF = 8;
  localparam int TAGS_PER_HOP_DEF = 8;

  // Input commands.
  localparam logic [1:0] CMD_SEND   = 2'd0;
  localparam logic [1:0] CMD_RECV   = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_IPV4      = 2'd0;
  localparam logic [1:0] KIND_ARP_REQ   = 2'd1;
  localparam logic [1:0] KIND_ARP_REPLY = 2'd2;
  localparam logic [1:0] KIND_DELIVER   = 2'd3;

  localparam logic [47:0] BROADCAST_MAC = 48'hFFFF_FFFF_FFFF;

  // Configuration register indexes and port widths.
  localparam int          REG_ADDR_W  = 5;
  localparam logic [1:0]  REG_OWN_MAC = 2'd0;
  localparam logic [1:0]  REG_OWN_IP  = 2'd1;
  localparam logic [1:0]  REG_LIFE    = 2'd2;
  localparam logic [1:0]  REG_RETRY   = 2'd3;
  localparam logic [31:0] LIFE_RESET  = 32'd30000;
  localparam logic [31:0] RETRY_RESET = 32'd5000;

  // Datapath operations issued by the controller.
  localparam logic [3:0] OP_IDLE       = 4'd0;
  localparam logic [3:0] OP_LATCH      = 4'd1;
  localparam logic [3:0] OP_SCAN       = 4'd2;
  localparam logic [3:0] OP_AGE        = 4'd3;
  localparam logic [3:0] OP_SEND       = 4'd4;
  localparam logic [3:0] OP_LEARN      = 4'd5;
  localparam logic [3:0] OP_FLUSH_RD   = 4'd6;
  localparam logic [3:0] OP_FLUSH_EMIT = 4'd7;
  localparam logic [3:0] OP_HOP_DROP   = 4'd8;
  localparam logic [3:0] OP_REPLY      = 4'd9;
  localparam logic [3:0] OP_DELIVER    = 4'd10;
  localparam logic [3:0] OP_FINISH     = 4'd11;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] hop_addr;
    logic [15:0] datagram_tag;
    logic [47:0] frame_dst_mac;
    logic        frame_is_ipv4;
    logic        payload_ok;
    logic        arp_is_request;
    logic [47:0] arp_sender_mac;
    logic [31:0] arp_sender_ip;
    logic [31:0] arp_target_ip;
    logic [31:0] elapsed_ms;
  } req_word_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [47:0] dest_mac;
    logic [15:0] out_tag;
    logic [31:0] arp_target_addr;
    logic [47:0] arp_target_hw;
    logic        last;
  } res_word_t;

  typedef struct packed {
    logic [47:0] own_mac;
    logic [31:0] own_ip;
    logic [31:0] entry_lifetime_ms;
    logic [31:0] retry_interval_ms;
  } cfg_t;

  typedef struct packed {
    logic [3:0] op;
  } ctl_cmd_t;

  typedef struct packed {
    logic       push_ok;
    logic       scan_last;
    logic       recv_pass;
    logic       is_ipv4;
    logic       learn_flush;
    logic       reply_due;
    logic       flush_more;
    logic [1:0] command;
  } dp_status_t;

endpackage

// File: hw/rtl/arc_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module arc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; read data holds when not read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/arc_regs.sv
// APB-style configuration registers of the ARP resolver cache.
`timescale 1ns / 1ps

module arc_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [arc_pkg::REG_ADDR_W-1:0]  paddr,
  input  logic [63:0]                     pwdata,
  output logic [63:0]                     prdata,
  output logic                            pready,
  output arc_pkg::cfg_t                   cfg
);

  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[4:3];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_mac           <= '0;
      cfg.own_ip            <= '0;
      cfg.entry_lifetime_ms <= arc_pkg::LIFE_RESET;
      cfg.retry_interval_ms <= arc_pkg::RETRY_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        arc_pkg::REG_OWN_MAC: cfg.own_mac           <= pwdata[47:0];
        arc_pkg::REG_OWN_IP:  cfg.own_ip            <= pwdata[31:0];
        arc_pkg::REG_LIFE:    cfg.entry_lifetime_ms <= pwdata[31:0];
        arc_pkg::REG_RETRY:   cfg.retry_interval_ms <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  // Read-back multiplexer.
  always_comb begin
    case (reg_idx)
      arc_pkg::REG_OWN_MAC: prdata = {16'd0, cfg.own_mac};
      arc_pkg::REG_OWN_IP:  prdata = {32'd0, cfg.own_ip};
      arc_pkg::REG_LIFE:    prdata = {32'd0, cfg.entry_lifetime_ms};
      arc_pkg::REG_RETRY:   prdata = {32'd0, cfg.retry_interval_ms};
      default:              prdata = '0;
    endcase
  end

endmodule

// File: hw/rtl/arc_dp.sv
// Datapath of the ARP resolver cache: tables, scan counter, tag RAM and result buffering.
`timescale 1ns / 1ps

module arc_dp #(
  parameter int MAP_ENTRIES  = arc_pkg::MAP_ENTRIES_DEF,
  parameter int PENDING_HOPS = arc_pkg::PENDING_HOPS_DEF,
  parameter int TAGS_PER_HOP = arc_pkg::TAGS_PER_HOP_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  arc_pkg::ctl_cmd_t    cmd,
  input  arc_pkg::req_word_t   req_word,
  input  arc_pkg::cfg_t        cfg,
  input  logic                 res_stall,
  output logic                 res_valid,
  output arc_pkg::res_word_t   res_word,
  output arc_pkg::dp_status_t  status
);

  localparam int SCAN_N = (MAP_ENTRIES > PENDING_HOPS) ? MAP_ENTRIES : PENDING_HOPS;
  localparam int IDX_W  = (SCAN_N > 1) ? $clog2(SCAN_N) : 1;
  localparam int MAP_W  = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
  localparam int HOP_W  = (PENDING_HOPS > 1) ? $clog2(PENDING_HOPS) : 1;
  localparam int CNT_W  = $clog2(TAGS_PER_HOP + 1);
  localparam int QDEPTH = PENDING_HOPS * TAGS_PER_HOP;
  localparam int Q_AW   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  // Latched item and scan state.
  arc_pkg::req_word_t item;
  logic [IDX_W-1:0]   idx;
  logic [CNT_W-1:0]   fi;

  logic               map_hit, map_free;
  logic [MAP_W-1:0]   map_hit_idx, map_free_idx;
  logic               hop_hit, hop_free;
  logic [HOP_W-1:0]   hop_hit_idx, hop_free_idx;

  // Address table and pending hop table.
  logic               map_valid [MAP_ENTRIES];
  logic [31:0]        map_ip    [MAP_ENTRIES];
  logic [47:0]        map_mac   [MAP_ENTRIES];
  logic [31:0]        map_rem   [MAP_ENTRIES];
  logic               hop_valid [PENDING_HOPS];
  logic [31:0]        hop_ip    [PENDING_HOPS];
  logic [31:0]        hop_retry [PENDING_HOPS];
  logic [CNT_W-1:0]   hop_count [PENDING_HOPS];

  // Result buffering: one held result, then the output register.
  logic               pend_valid;
  arc_pkg::res_word_t pend;
  arc_pkg::res_word_t pend_last;
  logic               emit_en;
  arc_pkg::res_word_t emit_res;
  logic               push_ok;

  // Tag RAM ports.
  logic               q_we, q_re;
  logic [Q_AW-1:0]    q_waddr, q_raddr;
  logic [15:0]        q_rdata;

  logic [31:0]        key;
  logic               map_in, hop_in;
  logic [MAP_W-1:0]   mi;
  logic [HOP_W-1:0]   hi;
  logic               map_expire, hop_expire;
  logic               for_own;

  assign key     = (item.command == arc_pkg::CMD_SEND) ? item.hop_addr : item.arp_sender_ip;
  assign mi      = idx[MAP_W-1:0];
  assign hi      = idx[HOP_W-1:0];
  assign map_in  = int'(idx) < MAP_ENTRIES;
  assign hop_in  = int'(idx) < PENDING_HOPS;
  assign map_expire = map_rem[mi] <= item.elapsed_ms;
  assign hop_expire = hop_retry[hi] <= item.elapsed_ms;
  assign for_own = item.arp_target_ip == cfg.own_ip;
  assign push_ok = !pend_valid || !res_valid || !res_stall;

  // Status towards the controller.
  always_comb begin
    status.push_ok     = push_ok;
    status.scan_last   = idx == IDX_W'(SCAN_N - 1);
    status.recv_pass   = ((item.frame_dst_mac == cfg.own_mac) ||
                          (item.frame_dst_mac == arc_pkg::BROADCAST_MAC)) && item.payload_ok;
    status.is_ipv4     = item.frame_is_ipv4;
    status.learn_flush = for_own && !map_hit && hop_hit;
    status.reply_due   = for_own && item.arp_is_request;
    status.flush_more  = fi < hop_count[hop_hit_idx];
    status.command     = item.command;
  end

  // Result produced by the current operation, if any.
  always_comb begin
    emit_en  = 1'b0;
    emit_res = '0;
    case (cmd.op)
      arc_pkg::OP_AGE: begin
        if (hop_in && hop_valid[hi] && hop_expire) begin
          emit_en                  = 1'b1;
          emit_res.result_kind     = arc_pkg::KIND_ARP_REQ;
          emit_res.dest_mac        = arc_pkg::BROADCAST_MAC;
          emit_res.arp_target_addr = hop_ip[hi];
        end
      end
      arc_pkg::OP_SEND: begin
        if (map_hit) begin
          emit_en              = 1'b1;
          emit_res.result_kind = arc_pkg::KIND_IPV4;
          emit_res.dest_mac    = map_mac[map_hit_idx];
          emit_res.out_tag     = item.datagram_tag;
        end else if (!hop_hit && hop_free) begin
          emit_en                  = 1'b1;
          emit_res.result_kind     = arc_pkg::KIND_ARP_REQ;
          emit_res.dest_mac        = arc_pkg::BROADCAST_MAC;
          emit_res.arp_target_addr = item.hop_addr;
        end
      end
      arc_pkg::OP_FLUSH_EMIT: begin
        emit_en              = 1'b1;
        emit_res.result_kind = arc_pkg::KIND_IPV4;
        emit_res.dest_mac    = item.arp_sender_mac;
        emit_res.out_tag     = q_rdata;
      end
      arc_pkg::OP_REPLY: begin
        emit_en                  = 1'b1;
        emit_res.result_kind     = arc_pkg::KIND_ARP_REPLY;
        emit_res.dest_mac        = item.arp_sender_mac;
        emit_res.arp_target_addr = item.arp_sender_ip;
        emit_res.arp_target_hw   = item.arp_sender_mac;
      end
      arc_pkg::OP_DELIVER: begin
        emit_en              = 1'b1;
        emit_res.result_kind = arc_pkg::KIND_DELIVER;
      end
      default: ;
    endcase
  end

  // Held result with its last flag raised, for the end of an item.
  always_comb begin
    pend_last      = pend;
    pend_last.last = 1'b1;
  end

  // Tag RAM addressing: slot within the hop's row.
  always_comb begin
    q_we    = 1'b0;
    q_waddr = '0;
    if (cmd.op == arc_pkg::OP_SEND && !map_hit) begin
      if (hop_hit) begin
        q_we    = hop_count[hop_hit_idx] < CNT_W'(TAGS_PER_HOP);
        q_waddr = Q_AW'(hop_hit_idx) * Q_AW'(TAGS_PER_HOP) + Q_AW'(hop_count[hop_hit_idx]);
      end else if (hop_free) begin
        q_we    = 1'b1;
        q_waddr = Q_AW'(hop_free_idx) * Q_AW'(TAGS_PER_HOP);
      end
    end
  end

  assign q_re    = cmd.op == arc_pkg::OP_FLUSH_RD;
  assign q_raddr = Q_AW'(hop_hit_idx) * Q_AW'(TAGS_PER_HOP) + Q_AW'(fi);

  arc_ram #(
    .WIDTH (16),
    .DEPTH (QDEPTH)
  ) u_tag_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (item.datagram_tag),
    .re    (q_re),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  // Item latch, scan counter and search results.
  always_ff @(posedge clk) begin
    case (cmd.op)
      arc_pkg::OP_LATCH: begin
        item     <= req_word;
        idx      <= '0;
        fi       <= '0;
        map_hit  <= 1'b0;
        map_free <= 1'b0;
        hop_hit  <= 1'b0;
        hop_free <= 1'b0;
      end
      arc_pkg::OP_SCAN: begin
        idx <= idx + 1'b1;
        if (map_in) begin
          if (map_valid[mi] && map_ip[mi] == key && !map_hit) begin
            map_hit     <= 1'b1;
            map_hit_idx <= mi;
          end
          if (!map_valid[mi] && !map_free) begin
            map_free     <= 1'b1;
            map_free_idx <= mi;
          end
        end
        if (hop_in) begin
          if (hop_valid[hi] && hop_ip[hi] == key && !hop_hit) begin
            hop_hit     <= 1'b1;
            hop_hit_idx <= hi;
          end
          if (!hop_valid[hi] && !hop_free) begin
            hop_free     <= 1'b1;
            hop_free_idx <= hi;
          end
        end
      end
      arc_pkg::OP_AGE:        idx <= idx + 1'b1;
      arc_pkg::OP_FLUSH_EMIT: fi  <= fi + 1'b1;
      default: ;
    endcase
  end

  // Table valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAP_ENTRIES; i++) begin
        map_valid[i] <= 1'b0;
      end
      for (int i = 0; i < PENDING_HOPS; i++) begin
        hop_valid[i] <= 1'b0;
      end
    end else begin
      case (cmd.op)
        arc_pkg::OP_AGE: begin
          if (map_in && map_valid[mi] && map_expire) begin
            map_valid[mi] <= 1'b0;
          end
        end
        arc_pkg::OP_SEND: begin
          if (!map_hit && !hop_hit && hop_free) begin
            hop_valid[hop_free_idx] <= 1'b1;
          end
        end
        arc_pkg::OP_LEARN: begin
          if (for_own && !map_hit && map_free) begin
            map_valid[map_free_idx] <= 1'b1;
          end
        end
        arc_pkg::OP_HOP_DROP: hop_valid[hop_hit_idx] <= 1'b0;
        default: ;
      endcase
    end
  end

  // Table contents.
  always_ff @(posedge clk) begin
    case (cmd.op)
      arc_pkg::OP_AGE: begin
        if (map_in && map_valid[mi] && !map_expire) begin
          map_rem[mi] <= map_rem[mi] - item.elapsed_ms;
        end
        if (hop_in && hop_valid[hi]) begin
          if (hop_expire) begin
            hop_retry[hi] <= cfg.retry_interval_ms;
          end else begin
            hop_retry[hi] <= hop_retry[hi] - item.elapsed_ms;
          end
        end
      end
      arc_pkg::OP_SEND: begin
        if (!map_hit) begin
          if (hop_hit) begin
            if (hop_count[hop_hit_idx] < CNT_W'(TAGS_PER_HOP)) begin
              hop_count[hop_hit_idx] <= hop_count[hop_hit_idx] + 1'b1;
            end
          end else if (hop_free) begin
            hop_ip[hop_free_idx]    <= item.hop_addr;
            hop_retry[hop_free_idx] <= cfg.retry_interval_ms;
            hop_count[hop_free_idx] <= CNT_W'(1);
          end
        end
      end
      arc_pkg::OP_LEARN: begin
        if (map_hit) begin
          map_mac[map_hit_idx] <= item.arp_sender_mac;
          map_rem[map_hit_idx] <= cfg.entry_lifetime_ms;
        end else if (for_own && map_free) begin
          map_ip[map_free_idx]  <= item.arp_sender_ip;
          map_mac[map_free_idx] <= item.arp_sender_mac;
          map_rem[map_free_idx] <= cfg.entry_lifetime_ms;
        end
      end
      default: ;
    endcase
  end

  // Handshake state of the held result and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (emit_en) begin
        pend_valid <= 1'b1;
        if (pend_valid) begin
          res_valid <= 1'b1;
        end else if (res_valid && !res_stall) begin
          res_valid <= 1'b0;
        end
      end else if (cmd.op == arc_pkg::OP_FINISH && pend_valid) begin
        pend_valid <= 1'b0;
        res_valid  <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload of the held result and the output register; held results carry last low.
  always_ff @(posedge clk) begin
    if (emit_en) begin
      pend <= emit_res;
      if (pend_valid) begin
        res_word <= pend;
      end
    end else if (cmd.op == arc_pkg::OP_FINISH && pend_valid) begin
      res_word <= pend_last;
    end
  end

  // A held result is only released as the last word of its item.
  assert property (@(posedge clk) disable iff (rst)
    ($fell(pend_valid) && !$past(rst)) |-> $past(cmd.op) == arc_pkg::OP_FINISH)
    else $error("held result dropped outside finish");

  // A flush never reads past the end of a hop's row.
  assert property (@(posedge clk) disable iff (rst)
    (cmd.op == arc_pkg::OP_FLUSH_RD) |-> int'(fi) < TAGS_PER_HOP)
    else $error("tag flush beyond row");

endmodule

// File: hw/rtl/arc_ctrl.sv
// Controller state machine of the ARP resolver cache.
`timescale 1ns / 1ps

module arc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  arc_pkg::dp_status_t  status,
  output arc_pkg::ctl_cmd_t    cmd
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_DISPATCH = 4'd1;
  localparam logic [3:0] ST_SCAN     = 4'd2;
  localparam logic [3:0] ST_SEND     = 4'd3;
  localparam logic [3:0] ST_LEARN    = 4'd4;
  localparam logic [3:0] ST_FLUSH_RD = 4'd5;
  localparam logic [3:0] ST_FLUSH_EM = 4'd6;
  localparam logic [3:0] ST_REPLY    = 4'd7;
  localparam logic [3:0] ST_DELIVER  = 4'd8;
  localparam logic [3:0] ST_AGE      = 4'd9;
  localparam logic [3:0] ST_FINISH   = 4'd10;

  logic [3:0] state, state_next;
  logic       accept;

  assign req_stall = rst || (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;

  // Next state and datapath operation.
  always_comb begin
    state_next = state;
    cmd.op     = arc_pkg::OP_IDLE;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.op     = arc_pkg::OP_LATCH;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (status.command)
          arc_pkg::CMD_SEND: state_next = ST_SCAN;
          arc_pkg::CMD_RECV: state_next = ST_SCAN;
          arc_pkg::CMD_TICK: state_next = ST_AGE;
          default:           state_next = ST_FINISH;
        endcase
      end
      ST_SCAN: begin
        cmd.op = arc_pkg::OP_SCAN;
        if (status.scan_last) begin
          if (status.command == arc_pkg::CMD_SEND) begin
            state_next = ST_SEND;
          end else if (!status.recv_pass) begin
            state_next = ST_FINISH;
          end else if (status.is_ipv4) begin
            state_next = ST_DELIVER;
          end else begin
            state_next = ST_LEARN;
          end
        end
      end
      ST_SEND: begin
        if (status.push_ok) begin
          cmd.op     = arc_pkg::OP_SEND;
          state_next = ST_FINISH;
        end
      end
      ST_LEARN: begin
        cmd.op = arc_pkg::OP_LEARN;
        if (status.learn_flush) begin
          state_next = ST_FLUSH_RD;
        end else if (status.reply_due) begin
          state_next = ST_REPLY;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_FLUSH_RD: begin
        if (status.flush_more) begin
          cmd.op     = arc_pkg::OP_FLUSH_RD;
          state_next = ST_FLUSH_EM;
        end else begin
          cmd.op     = arc_pkg::OP_HOP_DROP;
          state_next = status.reply_due ? ST_REPLY : ST_FINISH;
        end
      end
      ST_FLUSH_EM: begin
        if (status.push_ok) begin
          cmd.op     = arc_pkg::OP_FLUSH_EMIT;
          state_next = ST_FLUSH_RD;
        end
      end
      ST_REPLY: begin
        if (status.push_ok) begin
          cmd.op     = arc_pkg::OP_REPLY;
          state_next = ST_FINISH;
        end
      end
      ST_DELIVER: begin
        if (status.push_ok) begin
          cmd.op     = arc_pkg::OP_DELIVER;
          state_next = ST_FINISH;
        end
      end
      ST_AGE: begin
        if (status.push_ok) begin
          cmd.op = arc_pkg::OP_AGE;
          if (status.scan_last) begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (status.push_ok) begin
          cmd.op     = arc_pkg::OP_FINISH;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // An accepted word always starts work on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_DISPATCH)
    else $error("accepted word not dispatched");

  // Operations that may produce a result only run when the buffer can take it.
  assert property (@(posedge clk) disable iff (rst)
    (cmd.op == arc_pkg::OP_SEND || cmd.op == arc_pkg::OP_AGE ||
     cmd.op == arc_pkg::OP_FLUSH_EMIT || cmd.op == arc_pkg::OP_REPLY ||
     cmd.op == arc_pkg::OP_DELIVER || cmd.op == arc_pkg::OP_FINISH) |-> status.push_ok)
    else $error("result produced without room");

endmodule

// File: hw/rtl/arp_resolver_cache_top.sv
// Top level of the ARP resolver cache.
`timescale 1ns / 1ps
// Usage: request words (send, received frame or tick) enter on req_valid/req_stall;
// result words leave on res_valid/res_stall, the final word of each request marked
// by last. Configuration registers are written over the APB-style port, 64-bit data
// at byte addresses 0, 8, 16 and 24; the user must write them only while the block
// is idle, which the block itself does not enforce. Timing: one request is worked
// at a time. Every send, frame and tick walks one table entry per cycle across
// max(MAP_ENTRIES, PENDING_HOPS) entries, a tick pausing while the output is stalled;
// a flushed queue reads each queued tag from the tag RAM before it is emitted.
// Each result is held one word back so that its last flag is known, then placed in
// the output register when the next result is made or when the request finishes.
// Reset clears the address and pending tables' valid bits and loads the register
// defaults; no clearing pass is needed. When the receiver stalls, the output word
// holds and the block pauses at its next result until the output register frees.
module arp_resolver_cache_top #(
  parameter int MAP_ENTRIES  = arc_pkg::MAP_ENTRIES_DEF,
  parameter int PENDING_HOPS = arc_pkg::PENDING_HOPS_DEF,
  parameter int TAGS_PER_HOP = arc_pkg::TAGS_PER_HOP_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  arc_pkg::req_word_t              req_word,
  output logic                            res_valid,
  input  logic                            res_stall,
  output arc_pkg::res_word_t              res_word,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [arc_pkg::REG_ADDR_W-1:0]  paddr,
  input  logic [63:0]                     pwdata,
  output logic [63:0]                     prdata,
  output logic                            pready
);

  arc_pkg::cfg_t       cfg;
  arc_pkg::ctl_cmd_t   cmd;
  arc_pkg::dp_status_t status;

  arc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  arc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  arc_dp #(
    .MAP_ENTRIES  (MAP_ENTRIES),
    .PENDING_HOPS (PENDING_HOPS),
    .TAGS_PER_HOP (TAGS_PER_HOP)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req_word  (req_word),
    .cfg       (cfg),
    .res_stall (res_stall),
    .res_valid (res_valid),
    .res_word  (res_word),
    .status    (status)
  );

endmodule

// File: tb/tb_arp_resolver_cache_top.sv
// Self-checking testbench for the ARP resolver cache top level.
`timescale 1ns / 1ps

module tb_arp_resolver_cache_top;
  import arc_pkg::*;

  localparam int N_MAP  = MAP_ENTRIES_DEF;
  localparam int N_HOPS = PENDING_HOPS_DEF;
  localparam int N_TAGS = TAGS_PER_HOP_DEF;

  // Shadow of the resolver: tables, registers and the words still owed by the block.
  class arp_scoreboard;
    logic [47:0] own_mac;
    logic [31:0] own_ip;
    logic [31:0] life_ms;
    logic [31:0] retry_ms;
    bit          map_valid [N_MAP];
    logic [31:0] map_ip [N_MAP];
    logic [47:0] map_mac [N_MAP];
    logic [31:0] map_left [N_MAP];
    bit          hop_valid [N_HOPS];
    logic [31:0] hop_ip [N_HOPS];
    logic [31:0] hop_left [N_HOPS];
    int          hop_count [N_HOPS];
    logic [15:0] hop_tags [N_HOPS][N_TAGS];
    res_word_t   owed_words [$];
    int          errors;

    function new();
      own_mac  = '0;
      own_ip   = '0;
      life_ms  = LIFE_RESET;
      retry_ms = RETRY_RESET;
      errors   = 0;
      foreach (map_valid[i]) map_valid[i] = 0;
      foreach (hop_valid[i]) hop_valid[i] = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [63:0] val);
      case (idx)
        REG_OWN_MAC: own_mac = val[47:0];
        REG_OWN_IP:  own_ip = val[31:0];
        REG_LIFE:    life_ms = val[31:0];
        default:     retry_ms = val[31:0];
      endcase
    endfunction

    function void owe(ref res_word_t q[$], input logic [1:0] kind, input logic [47:0] mac,
                      input logic [15:0] tag, input logic [31:0] taddr,
                      input logic [47:0] thw);
      res_word_t r;
      r.result_kind     = kind;
      r.dest_mac        = mac;
      r.out_tag         = tag;
      r.arp_target_addr = taddr;
      r.arp_target_hw   = thw;
      r.last            = 1'b0;
      q.insert(q.size(), r);
    endfunction

    function int find_map(logic [31:0] ip);
      for (int i = 0; i < N_MAP; i++)
        if (map_valid[i] && map_ip[i] == ip) return i;
      return -1;
    endfunction

    function int find_hop(logic [31:0] ip);
      for (int i = 0; i < N_HOPS; i++)
        if (hop_valid[i] && hop_ip[i] == ip) return i;
      return -1;
    endfunction

    // Work out the words that one accepted request word causes.
    function void note_request(req_word_t w);
      res_word_t q [$];
      int m;
      int h;
      case (w.command)
        CMD_SEND: begin
          m = find_map(w.hop_addr);
          if (m >= 0) begin
            owe(q, KIND_IPV4, map_mac[m], w.datagram_tag, '0, '0);
          end else begin
            h = find_hop(w.hop_addr);
            if (h >= 0) begin
              if (hop_count[h] < N_TAGS) begin
                hop_tags[h][hop_count[h]] = w.datagram_tag;
                hop_count[h]++;
              end
            end else begin
              for (int i = 0; i < N_HOPS; i++) begin
                if (!hop_valid[i]) begin
                  hop_valid[i] = 1;
                  hop_ip[i] = w.hop_addr;
                  hop_left[i] = retry_ms;
                  hop_count[i] = 1;
                  hop_tags[i][0] = w.datagram_tag;
                  owe(q, KIND_ARP_REQ, BROADCAST_MAC, '0, w.hop_addr, '0);
                  break;
                end
              end
            end
          end
        end
        CMD_RECV: begin
          if ((w.frame_dst_mac == own_mac || w.frame_dst_mac == BROADCAST_MAC) &&
              w.payload_ok) begin
            if (w.frame_is_ipv4) begin
              owe(q, KIND_DELIVER, '0, '0, '0, '0);
            end else begin
              m = find_map(w.arp_sender_ip);
              if (m >= 0) begin
                map_mac[m] = w.arp_sender_mac;
                map_left[m] = life_ms;
              end
              if (w.arp_target_ip == own_ip) begin
                if (m < 0) begin
                  // Unknown sender aimed at us: learn it and release its queue.
                  for (int i = 0; i < N_MAP; i++) begin
                    if (!map_valid[i]) begin
                      map_valid[i] = 1;
                      map_ip[i] = w.arp_sender_ip;
                      map_mac[i] = w.arp_sender_mac;
                      map_left[i] = life_ms;
                      break;
                    end
                  end
                  h = find_hop(w.arp_sender_ip);
                  if (h >= 0) begin
                    for (int i = 0; i < hop_count[h]; i++)
                      owe(q, KIND_IPV4, w.arp_sender_mac, hop_tags[h][i], '0, '0);
                    hop_valid[h] = 0;
                  end
                end
                if (w.arp_is_request)
                  owe(q, KIND_ARP_REPLY, w.arp_sender_mac, '0, w.arp_sender_ip,
                      w.arp_sender_mac);
              end
            end
          end
        end
        CMD_TICK: begin
          for (int i = 0; i < N_MAP; i++) begin
            if (map_valid[i]) begin
              if (map_left[i] <= w.elapsed_ms) map_valid[i] = 0;
              else map_left[i] -= w.elapsed_ms;
            end
          end
          for (int i = 0; i < N_HOPS; i++) begin
            if (hop_valid[i]) begin
              if (hop_left[i] <= w.elapsed_ms) begin
                owe(q, KIND_ARP_REQ, BROADCAST_MAC, '0, hop_ip[i], '0);
                hop_left[i] = retry_ms;
              end else begin
                hop_left[i] -= w.elapsed_ms;
              end
            end
          end
        end
        default: ;
      endcase
      if (q.size() > 0) q[q.size()-1].last = 1'b1;
      foreach (q[i]) owed_words.insert(owed_words.size(), q[i]);
    endfunction

    // Compare one accepted result word with the oldest one owed.
    function void check_result(res_word_t r);
      res_word_t e;
      if (owed_words.size() == 0) begin
        $error("unexpected result word %h", r);
        errors++;
        return;
      end
      e = owed_words.pop_front();
      if (r.result_kind !== e.result_kind) begin
        $error("result_kind: expected %0d, got %0d", e.result_kind, r.result_kind);
        errors++;
      end
      if (r.dest_mac !== e.dest_mac) begin
        $error("dest_mac: expected %h, got %h", e.dest_mac, r.dest_mac);
        errors++;
      end
      if (r.out_tag !== e.out_tag) begin
        $error("out_tag: expected %h, got %h", e.out_tag, r.out_tag);
        errors++;
      end
      if (r.arp_target_addr !== e.arp_target_addr) begin
        $error("arp_target_addr: expected %h, got %h", e.arp_target_addr,
               r.arp_target_addr);
        errors++;
      end
      if (r.arp_target_hw !== e.arp_target_hw) begin
        $error("arp_target_hw: expected %h, got %h", e.arp_target_hw, r.arp_target_hw);
        errors++;
      end
      if (r.last !== e.last) begin
        $error("last: expected %b, got %b", e.last, r.last);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  req_valid;
  logic                  req_stall;
  req_word_t             req_word;
  logic                  res_valid;
  logic                  res_stall;
  res_word_t             res_word;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [REG_ADDR_W-1:0] paddr;
  logic [63:0]           pwdata;
  logic [63:0]           prdata;
  logic                  pready;

  arp_scoreboard resolver_shadow;
  bit            no_idle;
  logic [31:0]   hop_pool [20];
  int            stall_left;

  arp_resolver_cache_top dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
    .res_valid(res_valid), .res_stall(res_stall), .res_word(res_word),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Overall time limit.
  initial begin
    #20ms;
    $display("arp_resolver_cache_top test failed");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [47:0] rand48();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[47:0];
  endfunction

  // Receiver stalls: mostly short bursts, sometimes long ones.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      res_stall = 1'b1;
    end else if (!no_idle && $urandom_range(0, 99) < 20) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                               : $urandom_range(0, 2);
      res_stall = 1'b1;
    end else begin
      res_stall = 1'b0;
    end
  end

  // Result words are checked at the clock edge that accepts them.
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) resolver_shadow.check_result(res_word);
  end

  task automatic put_word(req_word_t w);
    int g;
    @(negedge clk);
    req_word = w;
    req_valid = 1'b1;
    do @(posedge clk); while (req_stall);
    resolver_shadow.note_request(w);
    g = gap_len();
    if (g > 0) begin
      @(negedge clk);
      req_valid = 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  task automatic reg_write(logic [1:0] idx, logic [63:0] val);
    @(negedge clk);
    req_valid = 1'b0;
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = REG_ADDR_W'(idx) << 3;
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    resolver_shadow.set_reg(idx, val);
  endtask

  // Hold the sender until every owed word has come and the block has gone quiet.
  task automatic drain();
    @(negedge clk);
    req_valid = 1'b0;
    while (resolver_shadow.owed_words.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_regs(logic [47:0] mac, logic [31:0] ip, logic [31:0] life,
                          logic [31:0] retry);
    drain();
    reg_write(REG_OWN_MAC, {16'h0, mac});
    reg_write(REG_OWN_IP, {32'h0, ip});
    reg_write(REG_LIFE, {32'h0, life});
    reg_write(REG_RETRY, {32'h0, retry});
  endtask

  function automatic req_word_t noise_word();
    req_word_t w;
    logic [287:0] raw;
    raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
           $urandom(), $urandom(), $urandom()};
    w = raw[$bits(req_word_t)-1:0];
    return w;
  endfunction

  function automatic req_word_t send_word(logic [31:0] ip, logic [15:0] tag);
    req_word_t w;
    w = noise_word();
    w.command = CMD_SEND;
    w.hop_addr = ip;
    w.datagram_tag = tag;
    return w;
  endfunction

  function automatic req_word_t arp_word(logic [47:0] dst, bit is_req,
                                         logic [47:0] smac, logic [31:0] sip,
                                         logic [31:0] tip);
    req_word_t w;
    w = noise_word();
    w.command = CMD_RECV;
    w.frame_dst_mac = dst;
    w.frame_is_ipv4 = 1'b0;
    w.payload_ok = 1'b1;
    w.arp_is_request = is_req;
    w.arp_sender_mac = smac;
    w.arp_sender_ip = sip;
    w.arp_target_ip = tip;
    return w;
  endfunction

  function automatic req_word_t tick_word(logic [31:0] ms);
    req_word_t w;
    w = noise_word();
    w.command = CMD_TICK;
    w.elapsed_ms = ms;
    return w;
  endfunction

  function automatic logic [31:0] pick_hop();
    return ($urandom_range(0, 4) == 0) ? hop_pool[$urandom_range(0, 19)]
                                       : hop_pool[$urandom_range(0, 9)];
  endfunction

  // Mostly well-formed traffic around a small set of hops, with some noise.
  function automatic req_word_t random_word();
    req_word_t w;
    logic [47:0] dst;
    int r;
    int d;
    r = $urandom_range(0, 99);
    d = $urandom_range(0, 99);
    dst = (d < 45) ? resolver_shadow.own_mac : (d < 80) ? BROADCAST_MAC : rand48();
    if (r < 36) begin
      w = send_word(pick_hop(), 16'($urandom()));
    end else if (r < 74) begin
      w = arp_word(dst, 1'($urandom_range(0, 1)), rand48(), pick_hop(),
                   ($urandom_range(0, 3) != 0) ? resolver_shadow.own_ip : $urandom());
      w.payload_ok = ($urandom_range(0, 9) != 0);
      w.frame_is_ipv4 = ($urandom_range(0, 5) == 0);
    end else if (r < 94) begin
      d = $urandom_range(0, 5);
      w = tick_word((d == 0) ? 32'd0 :
                    (d == 1) ? 32'hFFFF_FFFF :
                    (d == 2) ? $urandom() :
                    32'($urandom_range(1, 1 + resolver_shadow.retry_ms / 2 % 4000)));
    end else begin
      w = noise_word();
    end
    return w;
  endfunction

  initial begin
    req_word_t w;
    resolver_shadow = new();
    rst = 1'b1;
    req_valid = 1'b0;
    req_word = '0;
    res_stall = 1'b0;
    stall_left = 0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    no_idle = 1'b0;
    foreach (hop_pool[i]) hop_pool[i] = $urandom();
    hop_pool[0] = 32'h0;
    hop_pool[1] = 32'hFFFF_FFFF;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part at the reset timer values.
    set_regs(48'h0200_1234_5678, 32'hC0A8_0001, LIFE_RESET, RETRY_RESET);
    put_word(tick_word(32'd0));
    put_word(send_word(hop_pool[2], 16'h0000));
    put_word(send_word(hop_pool[2], 16'hFFFF));
    w = noise_word();
    w.command = CMD_UNUSED;
    put_word(w);
    w = arp_word(48'h0200_1234_5678, 1'b0, rand48(), hop_pool[3], 32'hC0A8_0001);
    w.frame_is_ipv4 = 1'b1;
    put_word(w);
    w.frame_dst_mac = BROADCAST_MAC;
    w.payload_ok = 1'b0;
    put_word(w);
    put_word(arp_word(48'h0200_1234_5679, 1'b1, rand48(), hop_pool[3], 32'hC0A8_0001));
    put_word(arp_word(BROADCAST_MAC, 1'b0, 48'hFFFF_FFFF_FFFE, hop_pool[2],
                      32'hC0A8_0001));
    put_word(send_word(hop_pool[2], 16'h1234));
    put_word(arp_word(48'h0200_1234_5678, 1'b1, 48'h0, hop_pool[4], 32'hC0A8_0001));
    put_word(arp_word(BROADCAST_MAC, 1'b1, rand48(), hop_pool[5], 32'h0A00_0001));
    put_word(arp_word(BROADCAST_MAC, 1'b0, rand48(), hop_pool[2], 32'h0A00_0001));
    put_word(tick_word(32'd4999));
    put_word(tick_word(32'd1));
    put_word(tick_word(32'hFFFF_FFFF));
    for (int i = 0; i < 9; i++) put_word(send_word(hop_pool[10 + i], 16'(i)));

    // Random phases, each under its own register settings.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_regs(rand48(), $urandom(), $urandom_range(200, 6000),
                    $urandom_range(100, 3000));
        1: set_regs(48'h0, 32'h0, 32'd1, 32'd1);
        2: set_regs(BROADCAST_MAC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        default: set_regs(rand48(), hop_pool[6], $urandom_range(1000, 40000),
                          $urandom_range(50, 800));
      endcase
      no_idle = (phase == 2);
      for (int i = 0; i < 40; i++) put_word(random_word());
      no_idle = 1'b0;
    end

    drain();
    if (resolver_shadow.errors == 0) begin
      $display("arp_resolver_cache_top test passed");
    end else begin
      $display("arp_resolver_cache_top test failed");
    end
    $finish;
  end
endmodule

// File: sim.f
hw/rtl/arc_pkg.sv
hw/rtl/arc_ram.sv
hw/rtl/arc_regs.sv
hw/rtl/arc_dp.sv
hw/rtl/arc_ctrl.sv
hw/rtl/arp_resolver_cache_top.sv
tb/tb_arp_resolver_cache_top.sv
